/* rtl/chnd_pkg.sv */
package chnd_pkg;

	localparam int MAX_ENTRIES = 2048;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int NAME_CHARS  = 8;
	localparam int NAME_W      = 64;
	localparam int HASH_W      = 32;
	localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Request to and response from the hash and modulo unit.
	typedef struct packed {
		logic               start;
		logic [NAME_W-1:0]  name;
		logic [CNT_W-1:0]   count;
	} hash_req_t;

	typedef struct packed {
		logic               done;
		logic [IDX_W-1:0]   bucket;
	} hash_rsp_t;

	// Upper-cases ASCII letters and zeroes every byte from the first NUL on.
	function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] res;
		logic              seen_nul;
		logic [7:0]        c;
		res      = '0;
		seen_nul = 1'b0;
		for (int i = 0; i < NAME_CHARS; i++) begin
			c = raw[8*i +: 8];
			if (c == 8'h00) begin
				seen_nul = 1'b1;
			end
			if (!seen_nul) begin
				if (c >= 8'h61 && c <= 8'h7A) begin
					res[8*i +: 8] = c - 8'h20;
				end else begin
					res[8*i +: 8] = c;
				end
			end
		end
		return res;
	endfunction

endpackage

/* rtl/chnd_ifs.sv */
interface chnd_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] entry_name;
	modport source (output valid, kind, entry_name, input ready);
	modport sink (input valid, kind, entry_name, output ready);
endinterface

interface chnd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [10:0] entry_index;
	modport source (output valid, status, entry_index, input ready);
	modport sink (input valid, status, entry_index, output ready);
endinterface

interface chnd_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] entry_count;
	modport source (output valid, entry_count, input ready);
	modport sink (input valid, entry_count, output ready);
endinterface

/* rtl/chnd_hash.sv */
module chnd_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  chnd_pkg::hash_req_t req,
	output chnd_pkg::hash_rsp_t rsp
);
	import chnd_pkg::*;

	typedef enum logic [2:0] {
		H_IDLE = 3'b001,
		H_HASH = 3'b010,
		H_MOD  = 3'b100
	} hstate_t;

	hstate_t             state_q;
	logic [HASH_W-1:0]   h_q;
	logic [NAME_W-1:0]   name_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rem_q;
	logic [4:0]          step_q;
	logic                done_q;
	logic [IDX_W-1:0]    bucket_q;
	logic [CNT_W-1:0]    rem_shift;
	logic [CNT_W-1:0]    rem_next;
	logic [7:0]          c;

	assign c         = name_q[7:0];
	assign rem_shift = {rem_q[CNT_W-2:0], h_q[HASH_W-1]};
	assign rem_next  = (rem_shift >= count_q) ? rem_shift - count_q : rem_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (req.start) begin
						state_q <= H_HASH;
						step_q  <= '0;
					end
				end
				H_HASH: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(NAME_CHARS - 1)) begin
						state_q <= H_MOD;
						step_q  <= '0;
					end
				end
				H_MOD: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(HASH_W - 1)) begin
						state_q <= H_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: begin
				h_q     <= HASH_SEED;
				name_q  <= req.name;
				count_q <= req.count;
				rem_q   <= '0;
			end
			H_HASH: begin
				// A zero byte marks the end; all later bytes are zero too.
				if (c != 8'h00) begin
					h_q <= (h_q << 5) ^ h_q ^ {24'd0, c};
				end
				name_q <= name_q >> 8;
			end
			H_MOD: begin
				rem_q    <= rem_next;
				h_q      <= h_q << 1;
				bucket_q <= rem_next[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.bucket = bucket_q;

`ifndef NO_ASSERTIONS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("hash done held longer than one cycle");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == H_MOD) |-> (rem_q < count_q)) else $error("remainder out of range");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && state_q != H_IDLE) |-> 1'b0) else $error("hash started while busy");
`endif

endmodule

/* rtl/chained_hash_name_directory_core.sv */
// The hash unit runs 8 hash steps and 32 modulo steps for every transaction.
// Throughput: one transaction at a time; input ready is low until the result is queued.
// Reset and every entry_count write start a clearing pass over all 2048 bucket heads,
// during which no input transaction is accepted.
module chained_hash_name_directory_core (
	input logic       clk,
	input logic       arst_n,
	chnd_in_if.sink   in_ch,
	chnd_out_if.source out_ch,
	chnd_cfg_if.sink  cfg_ch
);
	import chnd_pkg::*;

	// Sequencer states. The hash unit does the arithmetic; the sequencer then
	// either links a new entry or walks the bucket chain entry by entry (S_ENT_RD, S_ENT_CMP).
	typedef enum logic [8:0] {
		S_CLEAR   = 9'b000000001,
		S_IDLE    = 9'b000000010,
		S_HASH    = 9'b000000100,
		S_INS_RD  = 9'b000001000,
		S_INS_WR  = 9'b000010000,
		S_LK_HEAD = 9'b000100000,
		S_LK_NODE = 9'b001000000,
		S_ENT_RD  = 9'b010000000,
		S_ENT_CMP = 9'b100000000
	} state_t;

	localparam int HEAD_W = CNT_W;           // top bit set marks an empty link
	localparam int ENT_W  = NAME_W + HEAD_W; // canonical name plus next link
	localparam logic [HEAD_W-1:0] EMPTY_LINK = {1'b1, {IDX_W{1'b0}}};

	state_t             state_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   fill_q;
	logic               kind_q;
	logic [NAME_W-1:0]  canon_q;
	logic [IDX_W-1:0]   bucket_q;
	logic [HEAD_W-1:0]  node_q;
	logic               done_pend_q;
	status_t            res_status_q;
	logic [IDX_W-1:0]   res_idx_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [IDX_W-1:0]   out_idx_q;

	logic [HEAD_W-1:0]  head_mem [MAX_ENTRIES];
	logic [ENT_W-1:0]   ent_mem [MAX_ENTRIES];
	logic [HEAD_W-1:0]  head_rd_q;
	logic [ENT_W-1:0]   ent_rd_q;

	hash_req_t          hreq;
	hash_rsp_t          hrsp;
	logic               in_fire;
	logic               cfg_fire;
	logic               out_load;
	logic [CNT_W-1:0]   cfg_eff;

	assign in_ch.ready = (state_q == S_IDLE) && !done_pend_q;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign cfg_fire    = cfg_ch.valid;

	// Out-of-range counts are clamped once at write time.
	always_comb begin
		if (cfg_ch.entry_count == '0) begin
			cfg_eff = CNT_W'(1);
		end else if (cfg_ch.entry_count > CNT_W'(MAX_ENTRIES)) begin
			cfg_eff = CNT_W'(MAX_ENTRIES);
		end else begin
			cfg_eff = cfg_ch.entry_count;
		end
	end

	assign hreq.start = in_fire;
	assign hreq.name  = canon_name(in_ch.entry_name);
	assign hreq.count = count_q;

	chnd_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

	// A finished result moves to the output register once that register is free.
	assign out_load = done_pend_q && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			count_q     <= CNT_W'(1);
			fill_q      <= '0;
			done_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				done_pend_q <= 1'b0;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				count_q   <= cfg_eff;
				fill_q    <= '0;
				clr_idx_q <= '0;
				state_q   <= S_CLEAR;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_idx_q <= clr_idx_q + 1'b1;
						if (clr_idx_q == IDX_W'(MAX_ENTRIES - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_fire) begin
							state_q <= S_HASH;
						end
					end
					S_HASH: begin
						if (hrsp.done) begin
							if (kind_q == KIND_LOOKUP) begin
								state_q <= S_LK_HEAD;
							end else if (fill_q >= count_q) begin
								done_pend_q <= 1'b1;
								state_q     <= S_IDLE;
							end else begin
								state_q <= S_INS_RD;
							end
						end
					end
					S_INS_RD: state_q <= S_INS_WR;
					S_INS_WR: begin
						fill_q      <= fill_q + 1'b1;
						done_pend_q <= 1'b1;
						state_q     <= S_IDLE;
					end
					S_LK_HEAD: state_q <= S_LK_NODE;
					S_LK_NODE: begin
						if (head_rd_q[HEAD_W-1]) begin
							done_pend_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_ENT_RD;
						end
					end
					S_ENT_RD: state_q <= S_ENT_CMP;
					S_ENT_CMP: begin
						if (ent_rd_q[ENT_W-1 -: NAME_W] == canon_q ||
							ent_rd_q[HEAD_W-1]) begin
							done_pend_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_ENT_RD;
						end
					end
					default: state_q <= S_CLEAR;
				endcase
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q  <= in_ch.kind;
			canon_q <= hreq.name;
		end
		if (hrsp.done) begin
			bucket_q     <= hrsp.bucket;
			res_status_q <= ST_FULL;
			res_idx_q    <= '0;
		end
		if (state_q == S_INS_WR) begin
			res_status_q <= ST_INSERTED;
			res_idx_q    <= fill_q[IDX_W-1:0];
		end
		if (state_q == S_LK_NODE) begin
			node_q       <= head_rd_q;
			res_status_q <= ST_NOT_FOUND;
		end
		if (state_q == S_ENT_CMP) begin
			if (ent_rd_q[ENT_W-1 -: NAME_W] == canon_q) begin
				res_status_q <= ST_FOUND;
				res_idx_q    <= node_q[IDX_W-1:0];
			end else begin
				node_q <= ent_rd_q[HEAD_W-1:0];
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_idx_q    <= res_idx_q;
		end
	end

	// Bucket head memory: cleared by the sweep, written on insert.
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			head_mem[clr_idx_q] <= EMPTY_LINK;
		end else if (state_q == S_INS_WR) begin
			head_mem[bucket_q] <= {1'b0, fill_q[IDX_W-1:0]};
		end
		head_rd_q <= head_mem[bucket_q];
	end

	// Entry memory: canonical name and the link to the previous chain head.
	always_ff @(posedge clk) begin
		if (state_q == S_INS_WR) begin
			ent_mem[fill_q[IDX_W-1:0]] <= {canon_q, head_rd_q};
		end
		ent_rd_q <= ent_mem[node_q[IDX_W-1:0]];
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.entry_index = out_idx_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= count_q) else $error("fill count exceeds entry count");
	a_found_written: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FOUND) |-> ({1'b0, out_idx_q} < fill_q))
		else $error("found index was never written");
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ch.ready) else $error("input accepted during clear");
`endif

endmodule

/* tb/sv/tb_chained_hash_name_directory_core.sv */
`timescale 1ns / 100ps

module tb_chained_hash_name_directory_core;
	import chnd_pkg::*;

	localparam int NO_LINK = -1;

	logic clk;
	logic arst_n;

	chnd_in_if  in_ch ();
	chnd_out_if out_ch ();
	chnd_cfg_if cfg_ch ();

	chained_hash_name_directory_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// One expected directory answer, oldest at the front of the queue.
	typedef struct {
		status_t           status;
		logic [IDX_W-1:0]  index;
	} answer_t;

	answer_t pending_answers[$];

	// Shadow copy of the directory: chain heads, links, raw stored names,
	// the fill level and the programmed entry count.
	int                 shadow_head[MAX_ENTRIES];
	int                 shadow_link[MAX_ENTRIES];
	logic [NAME_W-1:0]  shadow_name[MAX_ENTRIES];
	int                 shadow_fill;
	logic [11:0]        shadow_count;

	int  error_count;
	int  items_sent;
	int  answers_seen;
	int  tally[4];
	bit  steady;

	// Rows of the directed part: either a register write or a transaction,
	// with the answer written out where it is obvious.
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef struct {
		row_kind_t          rk;
		logic [11:0]        cfg_value;
		logic               kind;
		logic [NAME_W-1:0]  entry_name;
		bit                 typed;
		status_t            status;
		logic [IDX_W-1:0]   index;
	} row_t;

	row_t directed_rows[$];

	// Random names are drawn from a small pool per phase so lookups hit.
	logic [NAME_W-1:0] name_pool[32];

	// The clock runs with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Folds lower-case ASCII letters to upper case and clears every byte from
	// the first NUL onward, which is the form names are compared in.
	function automatic logic [NAME_W-1:0] fold_name(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] res;
		logic [7:0]        c;
		res = '0;
		for (int i = 0; i < NAME_CHARS; i++) begin
			c = raw[8*i +: 8];
			if (c == 8'h00) begin
				break;
			end
			res[8*i +: 8] = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
		end
		return res;
	endfunction

	// djb2-style hash with every add replaced by xor, over the folded characters, stopping at the first NUL.
	function automatic logic [31:0] name_digest(input logic [NAME_W-1:0] folded);
		logic [31:0] h;
		logic [7:0]  c;
		h = 32'd5381;
		for (int i = 0; i < NAME_CHARS; i++) begin
			c = folded[8*i +: 8];
			if (c == 8'h00) begin
				break;
			end
			h = ((h << 5) ^ h) ^ {24'd0, c};
		end
		return h;
	endfunction

	function automatic int live_entries();
		if (shadow_count == 12'd0) begin
			return 1;
		end
		if (shadow_count > MAX_ENTRIES) begin
			return MAX_ENTRIES;
		end
		return int'(shadow_count);
	endfunction

	function automatic void empty_directory(input logic [11:0] value);
		shadow_count = value;
		shadow_fill  = 0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			shadow_head[i] = NO_LINK;
		end
	endfunction

	// Applies one accepted transaction to the shadow directory and returns
	// the answer the block has to give for it.
	function automatic answer_t directory_answer(input logic kind,
			input logic [NAME_W-1:0] raw);
		answer_t          ans;
		logic [NAME_W-1:0] folded;
		int               bucket;
		int               node;
		int               steps;
		folded    = fold_name(raw);
		bucket    = int'(name_digest(folded) % live_entries());
		ans.index = '0;
		if (kind == KIND_INSERT) begin
			if (shadow_fill >= live_entries()) begin
				ans.status = ST_FULL;
			end else begin
				ans.status                = ST_INSERTED;
				ans.index                 = shadow_fill[IDX_W-1:0];
				shadow_name[shadow_fill]  = raw;
				shadow_link[shadow_fill]  = shadow_head[bucket];
				shadow_head[bucket]       = shadow_fill;
				shadow_fill++;
			end
		end else begin
			// Head insertion means the first match in the chain is the
			// highest index that carries this name.
			ans.status = ST_NOT_FOUND;
			node       = shadow_head[bucket];
			steps      = 0;
			while (node != NO_LINK && steps < shadow_fill) begin
				if (fold_name(shadow_name[node]) == folded) begin
					ans.status = ST_FOUND;
					ans.index  = node[IDX_W-1:0];
					break;
				end
				node = shadow_link[node];
				steps++;
			end
		end
		return ans;
	endfunction

	// Writes the entry count. The caller makes sure nothing is in flight.
	// The valid stays up until the transaction; the next send lowers it.
	task automatic write_entry_count(input logic [11:0] value);
		in_ch.valid <= 1'b0;
		while (pending_answers.size() != 0) begin
			@(posedge clk);
		end
		cfg_ch.valid       <= 1'b1;
		cfg_ch.entry_count <= value;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		empty_directory(value);
	endtask

	// Offers one transaction, with random gaps in front of it unless steady is
	// set. If a typed answer is given it is queued instead of the predicted
	// one, but the shadow directory is always updated.
	task automatic send_item(input logic kind, input logic [NAME_W-1:0] raw,
			input bit typed, input answer_t typed_ans);
		answer_t ans;
		cfg_ch.valid <= 1'b0;
		while (!steady && $urandom_range(99) < 37) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.kind       <= kind;
		in_ch.entry_name <= raw;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		ans = directory_answer(kind, raw);
		pending_answers.push_back(typed ? typed_ans : ans);
		items_sent++;
	endtask

	function automatic void add_item(input logic kind, input logic [NAME_W-1:0] raw,
			input bit typed = 1'b0, input status_t st = ST_INSERTED,
			input int idx = 0);
		row_t r;
		r.rk         = ROW_ITEM;
		r.cfg_value  = '0;
		r.kind       = kind;
		r.entry_name = raw;
		r.typed      = typed;
		r.status     = st;
		r.index      = idx[IDX_W-1:0];
		directed_rows.push_back(r);
	endfunction

	function automatic void add_cfg(input logic [11:0] value);
		row_t r;
		r.rk         = ROW_CFG;
		r.cfg_value  = value;
		r.kind       = KIND_INSERT;
		r.entry_name = '0;
		r.typed      = 1'b0;
		r.status     = ST_INSERTED;
		r.index      = '0;
		directed_rows.push_back(r);
	endfunction

	// A base name of 0 to 8 characters, mostly letters, sometimes any
	// non-zero byte.
	function automatic logic [NAME_W-1:0] base_name();
		logic [NAME_W-1:0] n;
		int                len;
		n   = '0;
		len = $urandom_range(NAME_CHARS);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 80) begin
				n[8*i +: 8] = 8'h41 + 8'($urandom_range(25));
			end else begin
				n[8*i +: 8] = 8'($urandom_range(255, 1));
			end
		end
		return n;
	endfunction

	// Same name under another spelling: letters in random case and random
	// garbage behind the terminating NUL, all of which must compare equal.
	function automatic logic [NAME_W-1:0] respell(input logic [NAME_W-1:0] base);
		logic [NAME_W-1:0] n;
		logic [7:0]        c;
		bit                ended;
		n     = base;
		ended = 1'b0;
		for (int i = 0; i < NAME_CHARS; i++) begin
			c = base[8*i +: 8];
			if (ended) begin
				if ($urandom_range(1)) begin
					n[8*i +: 8] = 8'($urandom);
				end
			end else if (c == 8'h00) begin
				ended = 1'b1;
			end else if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1)) begin
				n[8*i +: 8] = c + 8'h20;
			end
		end
		return n;
	endfunction

	// The sink stalls at random, except during the steady stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= steady || ($urandom_range(99) >= 37);
		end
	end

	// Every result transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			answers_seen++;
			tally[out_ch.status]++;
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d index %0d",
					out_ch.status, out_ch.entry_index));
			end else begin
				want = pending_answers.pop_front();
				if (out_ch.status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %s",
						out_ch.status, want.status.name()));
				end
				if (out_ch.entry_index !== want.index) begin
					report_mismatch($sformatf("entry_index %0d, expected %0d",
						out_ch.entry_index, want.index));
				end
			end
		end
	end

	// Hard limit on the whole run, far beyond the slowest legal run.
	initial begin
		#60ms;
		$display("timeout with %0d results outstanding", pending_answers.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		answer_t       typed_ans;
		logic [11:0]   phase_counts[7];
		int            phase_items;
		logic          kind;
		logic [NAME_W-1:0] raw;

		clk               = 1'b0;
		arst_n            = 1'b0;
		steady            = 1'b0;
		error_count       = 0;
		items_sent        = 0;
		answers_seen      = 0;
		tally             = '{default: 0};
		in_ch.valid       <= 1'b0;
		in_ch.kind        <= KIND_INSERT;
		in_ch.entry_name  <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.entry_count <= 12'd1;
		empty_directory(12'd1);

		// Reset is held low first; the block then clears its buckets
		// and only accepts transactions once that pass is over.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. After reset there is room for one entry only.
		add_item(KIND_LOOKUP, 64'h41, 1, ST_NOT_FOUND, 0);
		add_item(KIND_INSERT, 64'h636261, 1, ST_INSERTED, 0);
		add_item(KIND_INSERT, 64'h5A5958, 1, ST_FULL, 0);
		add_item(KIND_LOOKUP, 64'h434241, 1, ST_FOUND, 0);
		add_item(KIND_LOOKUP, 64'h5A5958, 1, ST_NOT_FOUND, 0);
		// A count of zero behaves like one.
		add_cfg(12'd0);
		add_item(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_INSERTED, 0);
		add_item(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_FOUND, 0);
		add_item(KIND_INSERT, 64'h0, 1, ST_FULL, 0);
		// All ones is clamped to the maximum size.
		add_cfg(12'hFFF);
		add_item(KIND_INSERT, 64'h0, 1, ST_INSERTED, 0);
		add_item(KIND_LOOKUP, 64'h0, 1, ST_FOUND, 0);
		// Garbage behind a NUL is ignored, case of letters is ignored,
		// bytes above 0x7F are never folded.
		add_item(KIND_INSERT, 64'h3412EFCDAB007A7A);
		add_item(KIND_LOOKUP, 64'h5A5A);
		add_item(KIND_INSERT, 64'h386143646558494D);
		add_item(KIND_LOOKUP, 64'h386163444578696D);
		add_item(KIND_INSERT, 64'h61C0E1);
		add_item(KIND_LOOKUP, 64'h41C0E1);
		add_item(KIND_LOOKUP, 64'h61C0C1);
		add_item(KIND_INSERT, 64'h636261);
		add_item(KIND_LOOKUP, 64'h434241);
		add_item(KIND_LOOKUP, 64'h64636261);
		// Two entries: a duplicate name returns the later index.
		add_cfg(12'd2);
		add_item(KIND_INSERT, 64'h51, 1, ST_INSERTED, 0);
		add_item(KIND_INSERT, 64'h71, 1, ST_INSERTED, 1);
		add_item(KIND_INSERT, 64'h52, 1, ST_FULL, 0);
		add_item(KIND_LOOKUP, 64'h71, 1, ST_FOUND, 1);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].rk == ROW_CFG) begin
				write_entry_count(directed_rows[i].cfg_value);
			end else begin
				typed_ans.status = directed_rows[i].status;
				typed_ans.index  = directed_rows[i].index;
				send_item(directed_rows[i].kind, directed_rows[i].entry_name,
					directed_rows[i].typed, typed_ans);
			end
		end

		// Random part: several table sizes, the extremes among them. Most
		// transactions reuse a pool of names under varying spellings so that
		// chains grow and lookups hit; the rest is raw 64-bit noise.
		phase_counts = '{12'd0, 12'd2048, 12'd7, 12'd3, 12'hFFF, 12'd64, 12'd1500};
		foreach (phase_counts[p]) begin
			write_entry_count(phase_counts[p]);
			steady = (p == 3);
			foreach (name_pool[k]) begin
				name_pool[k] = base_name();
			end
			phase_items = 78;
			for (int n = 0; n < phase_items; n++) begin
				if ($urandom_range(99) < 10) begin
					kind = 1'($urandom_range(1));
					raw  = {$urandom, $urandom};
				end else begin
					kind = ($urandom_range(99) < 40) ? KIND_INSERT : KIND_LOOKUP;
					raw  = respell(name_pool[$urandom_range(31)]);
				end
				typed_ans = '{ST_INSERTED, '0};
				send_item(kind, raw, 1'b0, typed_ans);
			end
			steady = 1'b0;
		end

		cfg_ch.valid <= 1'b0;
		in_ch.valid  <= 1'b0;
		while (pending_answers.size() != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);

		$display("Sent %0d transactions over the directed rows and seven random entry counts,",
			items_sent);
		$display("%0d results checked: inserted %0d, found %0d, not found %0d, table full %0d.",
			answers_seen, tally[ST_INSERTED], tally[ST_FOUND], tally[ST_NOT_FOUND],
			tally[ST_FULL]);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", error_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
